### src/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W = 2 * OPERAND_WIDTH + 1;
  localparam int RAW_W = MAG_W + 1;
  localparam int RES_W = 33;
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5,
    OP_GT  = 3'd6,
    OP_LT  = 3'd7
  } op_t;

endpackage

### src/rau_div.sv
module rau_div
  import rau_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic             done,
  output logic [MAG_W-1:0] quotient
);

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[MAG_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? MAG_W'(trial - {1'b0, dvs}) : trial[MAG_W-1:0];
        quo <= {quo[MAG_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/rational_arithmetic_unit.sv
// Rational arithmetic unit: one item at a time, one shared multiplier,
// a shift/subtract GCD step and a bit-serial divider.
// Sequence: 3 multiply steps, a check, binary GCD steps, then two divisions
// (numerator, then denominator, by the GCD) and the output load; 0/0 skips the GCD
// and divisions and is flagged invalid. in_stall is high while an item is in work.
// Reset (rst, synchronous, active high) returns to idle and drops out_valid.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     opcode,
  input  logic signed [15:0]             a_numerator,
  input  logic signed [15:0]             a_denominator,
  input  logic signed [15:0]             b_numerator,
  input  logic signed [15:0]             b_denominator,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [RES_W-1:0]        result_numerator,
  output logic signed [RES_W-1:0]        result_denominator,
  output logic                           compare_true,
  output logic                           invalid
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_GCD  = 6'b001000,
    S_DIVN = 6'b010000,
    S_DIVD = 6'b100000
  } state_t;

  state_t state;
  logic   pend;

  op_t                             op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic [1:0]                      step;
  logic signed [RAW_W-1:0]         num, den;
  logic [MAG_W-1:0]                u, v, qn, qd;
  logic [CNT_W-1:0]                k;
  logic                            bad;

  logic signed [OPERAND_WIDTH-1:0]   mx, my;
  logic signed [2*OPERAND_WIDTH-1:0] prod;
  logic signed [RAW_W-1:0]           pext;
  logic [MAG_W-1:0]                  num_mag, den_mag, g_val, div_in, div_q;
  logic                              gcd_end, div_start, div_done;
  logic signed [RAW_W-1:0]           rn, rd;
  logic                              nz, dz, nneg, dneg, cmp;
  logic                              load_out;

  always_comb begin
    case (step)
      2'd0: begin
        mx = an;
        my = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        mx = bn;
        my = ad;
      end
      default: begin
        mx = ad;
        my = (op == OP_DIV) ? bn : bd;
      end
    endcase
  end

  assign prod    = mx * my;
  assign pext    = RAW_W'(prod);
  assign num_mag = num[RAW_W-1] ? MAG_W'(-num) : MAG_W'(num);
  assign den_mag = den[RAW_W-1] ? MAG_W'(-den) : MAG_W'(den);
  assign gcd_end = (u == '0) || (v == '0);
  assign g_val   = ((u == '0) ? v : u) << k;

  assign div_start = ((state == S_GCD) && gcd_end) || ((state == S_DIVN) && div_done);
  assign div_in    = (state == S_GCD) ? num_mag : den_mag;

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (g_val),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != S_IDLE) || pend;
  assign load_out = (state == S_IDLE) && pend && (!out_valid || !out_stall);

  assign rn   = num[RAW_W-1] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  assign rd   = den[RAW_W-1] ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
  assign nz   = num != '0;
  assign dz   = den != '0;
  assign nneg = num[RAW_W-1];
  assign dneg = den[RAW_W-1];

  always_comb begin
    case (op)
      OP_EQ:   cmp = !nz;
      OP_NE:   cmp = nz;
      OP_GT:   cmp = nz && dz && (nneg == dneg);
      OP_LT:   cmp = nz && dz && (nneg != dneg);
      default: cmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load_out) begin
            pend      <= 1'b0;
            if (bad) begin
              result_numerator   <= '0;
              result_denominator <= '0;
              compare_true       <= 1'b0;
              invalid            <= 1'b1;
            end else begin
              result_numerator   <= RES_W'(rn);
              result_denominator <= RES_W'(rd);
              compare_true       <= cmp;
              invalid            <= 1'b0;
            end
          end else if (in_valid && !pend) begin
            op    <= op_t'(opcode);
            an    <= a_numerator[OPERAND_WIDTH-1:0];
            ad    <= a_denominator[OPERAND_WIDTH-1:0];
            bn    <= b_numerator[OPERAND_WIDTH-1:0];
            bd    <= b_denominator[OPERAND_WIDTH-1:0];
            step  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 2'd1;
          case (step)
            2'd0: num <= pext;
            2'd1: begin
              if (op == OP_ADD) num <= num + pext;
              else if (op != OP_MUL && op != OP_DIV) num <= num - pext;
            end
            default: begin
              den   <= pext;
              state <= S_CHK;
            end
          endcase
        end
        S_CHK: begin
          k <= '0;
          u <= num_mag;
          v <= den_mag;
          if (!nz && !dz) begin
            bad   <= 1'b1;
            pend  <= 1'b1;
            state <= S_IDLE;
          end else begin
            bad   <= 1'b0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_end) begin
            state <= S_DIVN;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            qn    <= div_q;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            qd    <= div_q;
            pend  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
